/* rtl/pst_pkg.sv */
`default_nettype none

package pst_pkg;

   typedef enum logic [1:0] {
      MODE_MONO8  = 2'd0,
      MODE_YUV411 = 2'd1,
      MODE_YUV422 = 2'd2,
      MODE_RGB24  = 2'd3
   } mode_type;

   typedef logic [2:0] phase_type;

   localparam phase_type PHASE_0 = 3'd0;
   localparam phase_type PHASE_1 = 3'd1;
   localparam phase_type PHASE_2 = 3'd2;
   localparam phase_type PHASE_3 = 3'd3;
   localparam phase_type PHASE_4 = 3'd4;
   localparam phase_type PHASE_5 = 3'd5;

   localparam logic [7:0] CHROMA_MID = 8'd128;

   // one accepted transaction, with the held bytes as they stood before it
   typedef struct packed {
      mode_type   mode;
      phase_type  phase;
      logic [7:0] data;
      logic       fend;
      logic [7:0] held0;
      logic [7:0] held1;
   } stage_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } ycc_type;

endpackage

`default_nettype wire

/* rtl/pst_ycc.sv */
`default_nettype none

module pst_ycc (
   input  wire logic [7:0]      r,
   input  wire logic [7:0]      g,
   input  wire logic [7:0]      b,
   output pst_pkg::ycc_type     ycc
);
   import pst_pkg::*;

   // divide by 2^15, truncating toward zero
   function automatic logic signed [9:0] div_q15(input logic signed [24:0] x);
      logic signed [24:0] t;
      begin
         t = (x < 0) ? (x + 25'sd32767) : x;
         t = t >>> 15;
         div_q15 = $signed(t[9:0]);
      end
   endfunction

   function automatic logic [7:0] clamp8(input logic signed [10:0] x);
      begin
         if (x < 0) begin
            clamp8 = 8'd0;
         end else if (x > 11'sd255) begin
            clamp8 = 8'd255;
         end else begin
            clamp8 = x[7:0];
         end
      end
   endfunction

   logic signed [24:0] rs, gs, bs;
   logic signed [24:0] ysum, usum, vsum;
   logic signed [10:0] yq, uq, vq;

   always_comb begin
      rs   = $signed({17'd0, r});
      gs   = $signed({17'd0, g});
      bs   = $signed({17'd0, b});
      ysum = rs * 25'sd9798 + gs * 25'sd19235 + bs * 25'sd3736;
      usum = bs * 25'sd14221 - rs * 25'sd4784 - gs * 25'sd9437;
      vsum = rs * 25'sd20218 - gs * 25'sd16941 - bs * 25'sd3277;
      yq   = 11'(div_q15(ysum));
      uq   = 11'(div_q15(usum)) + 11'sd128;
      vq   = 11'(div_q15(vsum)) + 11'sd128;
      ycc.y = clamp8(yq);
      ycc.u = clamp8(uq);
      ycc.v = clamp8(vq);
   end

endmodule

`default_nettype wire

/* rtl/pst_front.sv */
`default_nettype none

module pst_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_pixel_mode,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_frame_end,
   input  wire logic               take,
   output logic                    s1_valid,
   output pst_pkg::stage_type      s1
);
   import pst_pkg::*;

   mode_type   mode_ff;
   phase_type  phase_ff, phase_in, ph;
   logic [7:0] held_ff [2];
   logic [7:0] held_in [2];
   logic       s1_valid_ff;
   stage_type  s1_ff;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_ready = !s1_valid_ff || take;
   assign accept    = req_valid && req_ready;
   assign s1_valid  = s1_valid_ff;
   assign s1        = s1_ff;

   always_comb begin
      ph         = (phase_ff > PHASE_5) ? PHASE_0 : phase_ff;
      phase_in   = PHASE_0;
      held_in[0] = held_ff[0];
      held_in[1] = held_ff[1];
      case (mode_ff)
         MODE_YUV411: begin
            phase_in = (ph == PHASE_5) ? PHASE_0 : ph + 3'd1;
            if (ph == PHASE_0) held_in[0] = req_in_byte;
            if (ph == PHASE_3) held_in[1] = req_in_byte;
         end
         MODE_RGB24: begin
            phase_in = (ph == PHASE_5) ? PHASE_0 : ph + 3'd1;
            if (ph == PHASE_0 || ph == PHASE_3) held_in[0] = req_in_byte;
            if (ph == PHASE_1 || ph == PHASE_4) held_in[1] = req_in_byte;
         end
         default: begin
            phase_in = PHASE_0;
         end
      endcase
      if (req_frame_end) phase_in = PHASE_0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_MONO8;
         phase_ff    <= PHASE_0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff  <= mode_type'(csr_pixel_mode);
            phase_ff <= PHASE_0;
         end else if (accept) begin
            phase_ff <= phase_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (take) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff[0]  <= held_in[0];
         held_ff[1]  <= held_in[1];
         s1_ff.mode  <= mode_ff;
         s1_ff.phase <= ph;
         s1_ff.data  <= req_in_byte;
         s1_ff.fend  <= req_frame_end;
         s1_ff.held0 <= held_ff[0];
         s1_ff.held1 <= held_ff[1];
      end
   end

endmodule

`default_nettype wire

/* rtl/pst_pack.sv */
`default_nettype none

module pst_pack (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               s1_valid,
   input  wire pst_pkg::stage_type s1,
   output logic                    take,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_last,
   output logic                    rsp_frame_done
);
   import pst_pkg::*;

   ycc_type    ycc;
   logic [7:0] grp_in [4];
   logic [2:0] count_in;
   logic [7:0] avg_u, avg_v;

   logic       s2_valid_ff;
   logic [1:0] idx_ff;
   logic [1:0] last_idx_ff;
   logic       fend_ff;
   logic [7:0] grp_ff [4];
   ycc_type    first_ff;
   logic       is_last;
   logic       load;

   pst_ycc u_ycc (
      .r   (s1.held0),
      .g   (s1.held1),
      .b   (s1.data),
      .ycc (ycc)
   );

   assign is_last        = (idx_ff == last_idx_ff);
   assign take           = !s2_valid_ff || (rsp_ready && is_last);
   assign load           = s1_valid && take;
   assign rsp_valid      = s2_valid_ff;
   assign rsp_out_byte   = grp_ff[idx_ff];
   assign rsp_run_last   = is_last;
   assign rsp_frame_done = is_last && fend_ff;

   always_comb begin
      avg_u     = 8'(({1'b0, first_ff.u} + {1'b0, ycc.u}) >> 1);
      avg_v     = 8'(({1'b0, first_ff.v} + {1'b0, ycc.v}) >> 1);
      grp_in[0] = s1.data;
      grp_in[1] = s1.held0;
      grp_in[2] = ycc.y;
      grp_in[3] = avg_v;
      count_in  = 3'd0;
      case (s1.mode)
         MODE_MONO8: begin
            grp_in[1] = CHROMA_MID;
            count_in  = 3'd2;
         end
         MODE_YUV411: begin
            case (s1.phase)
               PHASE_1, PHASE_4: count_in = 3'd2;
               PHASE_2, PHASE_3: count_in = 3'd1;
               PHASE_5: begin
                  grp_in[1] = s1.held1;
                  count_in  = 3'd2;
               end
               default: count_in = 3'd0;
            endcase
         end
         MODE_YUV422: begin
            count_in = 3'd1;
         end
         default: begin
            grp_in[0] = first_ff.y;
            grp_in[1] = avg_u;
            count_in  = (s1.phase == PHASE_5) ? 3'd4 : 3'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         idx_ff      <= 2'd0;
      end else begin
         if (load) begin
            s2_valid_ff <= (count_in != 3'd0);
            idx_ff      <= 2'd0;
         end else if (s2_valid_ff && rsp_ready) begin
            if (is_last) begin
               s2_valid_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff[0]   <= grp_in[0];
         grp_ff[1]   <= grp_in[1];
         grp_ff[2]   <= grp_in[2];
         grp_ff[3]   <= grp_in[3];
         last_idx_ff <= 2'(count_in - 3'd1);
         fend_ff     <= s1.fend;
      end
      if (load && s1.mode == MODE_RGB24 && s1.phase == PHASE_2) begin
         first_ff <= ycc;
      end
   end

endmodule

`default_nettype wire

/* rtl/pixel_stream_to_yuy2.sv */
// An accepted transaction is registered in the input register, then loaded into the output group
// register, whose bytes go out on rsp one output byte per cycle while rsp_ready is high; an input
// byte waits in the input register until the group register is empty or sends its last byte.
// Input register and output group register overlap, so input is taken while output drains.
// Reset (synchronous, active high) sets mode to mono8, group phase to 0 and empties both stages.
`default_nettype none

module pixel_stream_to_yuy2 (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_pixel_mode,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_frame_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_frame_done
);
   import pst_pkg::*;

   stage_type s1;
   logic      s1_valid;
   logic      take;

   pst_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_pixel_mode (csr_pixel_mode),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_frame_end  (req_frame_end),
      .take           (take),
      .s1_valid       (s1_valid),
      .s1             (s1)
   );

   pst_pack u_pack (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid),
      .s1             (s1),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire

/* bench/yuy2_scoreboard_pkg.sv */
package yuy2_scoreboard_pkg;
   import pst_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       frame_done;
   } yuy2_beat_type;

   class yuy2_scoreboard;
      mode_type      mode;
      phase_type     phase;
      logic [7:0]    held [2];
      ycc_type       first_px;
      yuy2_beat_type expected_beats [$];
      int            errors;

      function new();
         mode     = MODE_MONO8;
         phase    = PHASE_0;
         held[0]  = 8'd0;
         held[1]  = 8'd0;
         first_px = '0;
         errors   = 0;
      endfunction

      function void set_mode(mode_type m);
         mode  = m;
         phase = PHASE_0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function logic [7:0] clamp8(int x);
         if (x < 0) return 8'd0;
         if (x > 255) return 8'd255;
         return x[7:0];
      endfunction

      // Q15 coefficients, signed division truncates toward zero
      function ycc_type rgb_to_ycc(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int      ri;
         int      gi;
         int      bi;
         ycc_type c;
         ri  = r;
         gi  = g;
         bi  = b;
         c.y = clamp8((9798 * ri + 19235 * gi + 3736 * bi) / 32768);
         c.u = clamp8((-4784 * ri - 9437 * gi + 14221 * bi) / 32768 + 128);
         c.v = clamp8((20218 * ri - 16941 * gi - 3277 * bi) / 32768 + 128);
         return c;
      endfunction

      function logic [7:0] avg_floor(logic [7:0] a, logic [7:0] b);
         int s;
         s = (int'(a) + int'(b)) >> 1;
         return s[7:0];
      endfunction

      function void note_input(logic [7:0] b, logic fe);
         logic [7:0]    beats [$];
         ycc_type       second_px;
         phase_type     nxt;
         yuy2_beat_type e;
         nxt = PHASE_0;
         case (mode)
            MODE_MONO8: begin
               beats.push_back(b);
               beats.push_back(CHROMA_MID);
            end
            MODE_YUV411: begin
               nxt = phase + 3'd1;
               case (phase)
                  PHASE_0: held[0] = b;
                  PHASE_1: begin
                     beats.push_back(b);
                     beats.push_back(held[0]);
                  end
                  PHASE_2: beats.push_back(b);
                  PHASE_3: begin
                     held[1] = b;
                     beats.push_back(b);
                  end
                  PHASE_4: begin
                     beats.push_back(b);
                     beats.push_back(held[0]);
                  end
                  default: begin
                     beats.push_back(b);
                     beats.push_back(held[1]);
                     nxt = PHASE_0;
                  end
               endcase
            end
            MODE_YUV422: beats.push_back(b);
            default: begin
               nxt = phase + 3'd1;
               case (phase)
                  PHASE_0, PHASE_3: held[0] = b;
                  PHASE_1, PHASE_4: held[1] = b;
                  PHASE_2: first_px = rgb_to_ycc(held[0], held[1], b);
                  default: begin
                     second_px = rgb_to_ycc(held[0], held[1], b);
                     beats.push_back(first_px.y);
                     beats.push_back(avg_floor(first_px.u, second_px.u));
                     beats.push_back(second_px.y);
                     beats.push_back(avg_floor(first_px.v, second_px.v));
                     nxt = PHASE_0;
                  end
               endcase
            end
         endcase
         phase = fe ? PHASE_0 : nxt;
         foreach (beats[i]) begin
            e.data       = beats[i];
            e.run_last   = (i == beats.size() - 1);
            e.frame_done = (i == beats.size() - 1) && fe;
            expected_beats.push_back(e);
         end
      endfunction

      function void check_result(logic [7:0] d, logic rl, logic fd);
         yuy2_beat_type e;
         if (expected_beats.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected transaction: byte %02h last %0b done %0b", d, rl, fd);
            return;
         end
         e = expected_beats.pop_front();
         if (e.data !== d || e.run_last !== rl || e.frame_done !== fd) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected byte %02h last %0b done %0b, got %02h %0b %0b",
                        e.data, e.run_last, e.frame_done, d, rl, fd);
         end
      endfunction
   endclass

endpackage

/* bench/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pst_pkg::*;
   import yuy2_scoreboard_pkg::*;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       csr_valid      = 1'b0;
   logic [1:0] csr_pixel_mode = 2'd0;
   logic       req_valid      = 1'b0;
   logic [7:0] req_in_byte    = 8'd0;
   logic       req_frame_end  = 1'b0;
   logic       rsp_ready      = 1'b0;
   logic       csr_ready;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_frame_done;

   bit quiet = 1'b0;

   yuy2_scoreboard board = new();

   pixel_stream_to_yuy2 u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_pixel_mode (csr_pixel_mode),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.set_mode(mode_type'(csr_pixel_mode));
         if (req_valid && req_ready) board.note_input(req_in_byte, req_frame_end);
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_out_byte, rsp_run_last, rsp_frame_done);
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // called and returns at a falling edge
   task send_byte(input logic [7:0] b, input logic fe);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_frame_end <= fe;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task write_mode(input mode_type m);
      csr_valid      <= 1'b1;
      csr_pixel_mode <= m;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // let results drain, then cover transactions that produce no output
   task wait_idle();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (board.pending() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (6) @(negedge clock);
   endtask

   initial begin
      mode_type m;
      int       since_end;
      logic     fe;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_mode(MODE_MONO8);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      wait_idle();
      write_mode(MODE_YUV411);
      send_byte(8'h80, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'hEB, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h33, 1'b1);

      wait_idle();
      write_mode(MODE_YUV422);
      send_byte(8'hFF, 1'b1);

      // clamp high on red chroma, clamp low on cyan chroma, white and black
      wait_idle();
      write_mode(MODE_RGB24);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7E, 1'b1);

      for (int k = 0; k < 8; k++) begin
         wait_idle();
         m = (k < 4) ? mode_type'(3 - k) : mode_type'($urandom_range(0, 3));
         write_mode(m);
         if (k == 7) quiet = 1'b1;
         since_end = 0;
         for (int i = 0; i < 23; i++) begin
            if ($urandom_range(0, 15) == 0)
               fe = 1'b1;
            else
               fe = (since_end % 6 == 5) && ($urandom_range(0, 3) == 0);
            send_byte(8'($urandom_range(0, 255)), fe);
            since_end = fe ? 0 : since_end + 1;
         end
      end

      wait_idle();
      if (board.pending() != 0) board.errors++;
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
